// ===== design/pida_pkg.sv =====
// Shared types and codes for the positional insert/delete list.
// Used by the controller, the datapath and the port checker.
package pida_pkg;

    localparam logic [2:0] CMD_INS_POS   = 3'd0;
    localparam logic [2:0] CMD_INS_FRONT = 3'd1;
    localparam logic [2:0] CMD_INS_END   = 3'd2;
    localparam logic [2:0] CMD_DEL_POS   = 3'd3;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic latch;
        logic exec;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_stat;

endpackage

// ===== design/positional_insert_delete_array_core.sv =====
// Ordered list of up to DEPTH signed 32-bit entries with positional insert and delete.
// Each command is transferred in, then applied to the list (the affected cells shift in
// parallel), then dumped as one result per cycle while the output is not stalled; an empty
// list gives a single no-entry result. The dump is bounded by the single output register,
// fed from cell 0 while the live entries rotate. Input stall is held through the dump;
// the last result may still wait in the output register as the next command transfers in.
// Depends on pida_pkg, pida_ctrl and pida_dp.
module positional_insert_delete_array_core import pida_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_position,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value_res,
    output logic [3:0]         o_index,
    output logic               o_last,
    output logic               o_no_entry,
    output logic [1:0]         o_status
);

    t_dp_cmd  w_ctl;
    t_dp_stat w_sts;

    pida_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    pida_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_position  (i_position),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_value_res (o_value_res),
        .o_index     (o_index),
        .o_last      (o_last),
        .o_no_entry  (o_no_entry),
        .o_status    (o_status)
    );

endmodule

// ===== design/pida_ctrl.sv =====
// Sequencer for the list: take a command, apply it, then walk the dump.
// Depends on pida_pkg for the command and status structs.
module pida_ctrl import pida_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_sts,
    output t_dp_cmd  o_ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   w_accept;

    assign w_accept = i_valid && !r_busy;
    assign o_stall  = r_busy;

    assign o_ctl.latch = w_accept;
    assign o_ctl.exec  = (r_state == S_EXEC);
    assign o_ctl.emit  = (r_state == S_DUMP) && i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_DUMP;
                end
                S_DUMP: begin
                    if (i_sts.out_free && i_sts.last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== design/pida_dp.sv =====
// Datapath: entry cells with neighbor shifts, count, status and the output register.
// Depends on pida_pkg; sequenced by pida_ctrl.
module pida_dp import pida_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_position,
    input  t_dp_cmd            i_ctl,
    output t_dp_stat           o_sts,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [31:0] o_value_res,
    output logic [3:0]         o_index,
    output logic               o_last,
    output logic               o_no_entry,
    output logic [1:0]         o_status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    logic [2:0]         r_cmd;
    logic signed [31:0] r_value;
    logic [4:0]         r_pos;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [1:0]         r_status;
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic [3:0]         r_out_index;
    logic               r_out_last;
    logic               r_out_no_entry;
    logic [1:0]         r_out_status;

    logic signed [31:0] r_entries [DEPTH];
    logic signed [31:0] n_entries [DEPTH];
    logic signed [31:0] w_lo [DEPTH];
    logic signed [31:0] w_hi [DEPTH];

    logic [PW-1:0] w_cnt;
    logic [PW-1:0] w_cnt_m1;
    logic [PW-1:0] w_eff;
    logic          w_is_ins;
    logic          w_is_del;
    logic          w_do_ins;
    logic          w_do_del;
    logic [1:0]    w_status;
    logic          w_empty;
    logic          w_last;

    assign w_cnt    = PW'(r_count);
    assign w_cnt_m1 = w_cnt - PW'(1);
    assign w_empty  = (r_count == '0);
    assign w_last   = w_empty || (r_idx == r_count - CW'(1));

    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_sts.last     = w_last;

    always_comb begin
        w_is_ins = 1'b0;
        w_is_del = 1'b0;
        w_eff    = '0;
        case (r_cmd)
            CMD_INS_POS: begin
                w_is_ins = 1'b1;
                w_eff    = PW'(r_pos);
            end
            CMD_INS_FRONT: begin
                w_is_ins = 1'b1;
            end
            CMD_INS_END: begin
                w_is_ins = 1'b1;
                w_eff    = w_cnt;
            end
            CMD_DEL_POS: begin
                w_is_del = 1'b1;
                w_eff    = PW'(r_pos);
            end
            CMD_DEL_FRONT: begin
                w_is_del = 1'b1;
            end
            default: begin
                w_is_ins = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_status = ST_OK;
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        if (w_is_ins) begin
            if (r_count == CW'(DEPTH)) begin
                w_status = ST_FULL;
            end else if (w_eff > w_cnt) begin
                w_status = ST_BADPOS;
            end else begin
                w_do_ins = 1'b1;
            end
        end else if (w_is_del) begin
            if (w_empty) begin
                w_status = ST_EMPTY;
            end else if (w_eff >= w_cnt) begin
                w_status = ST_BADPOS;
            end else begin
                w_do_del = 1'b1;
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
        if (g > 0) begin : g_lo
            assign w_lo[g] = r_entries[g-1];
        end else begin : g_lo0
            assign w_lo[g] = r_entries[0];
        end
        if (g < DEPTH - 1) begin : g_hi
            assign w_hi[g] = r_entries[g+1];
        end else begin : g_hiN
            assign w_hi[g] = r_entries[0];
        end
    end

    // insert shifts up, delete shifts down, dump rotates the live entries left
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (i_ctl.exec && w_do_ins) begin
                if (PW'(i) == w_eff) begin
                    n_entries[i] = r_value;
                end else if (PW'(i) > w_eff) begin
                    n_entries[i] = w_lo[i];
                end
            end else if (i_ctl.exec && w_do_del) begin
                if (PW'(i) >= w_eff) begin
                    n_entries[i] = w_hi[i];
                end
            end else if (i_ctl.emit && !w_empty) begin
                if (PW'(i) == w_cnt_m1) begin
                    n_entries[i] = r_entries[0];
                end else if (PW'(i) < w_cnt_m1) begin
                    n_entries[i] = w_hi[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
        if (i_ctl.latch) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (i_ctl.exec) begin
            r_status <= w_status;
        end
        if (i_ctl.emit) begin
            r_out_value    <= w_empty ? 32'sd0 : r_entries[0];
            r_out_index    <= 4'(r_idx);
            r_out_last     <= w_last;
            r_out_no_entry <= w_empty;
            r_out_status   <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.exec && w_do_ins) begin
                r_count <= r_count + CW'(1);
            end else if (i_ctl.exec && w_do_del) begin
                r_count <= r_count - CW'(1);
            end
            if (i_ctl.latch) begin
                r_idx <= '0;
            end else if (i_ctl.emit) begin
                r_idx <= w_last ? '0 : r_idx + CW'(1);
            end
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_index     = r_out_index;
    assign o_last      = r_out_last;
    assign o_no_entry  = r_out_no_entry;
    assign o_status    = r_out_status;

endmodule

// ===== design/pida_checker.sv =====
// Port-level checks for positional_insert_delete_array_core, bound to the top level.
// Depends on pida_pkg for the status codes.
module pida_checker import pida_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_value_res,
    input logic [3:0]         o_index,
    input logic               o_last,
    input logic               o_no_entry,
    input logic [1:0]         o_status
);

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_entry |-> o_last && (o_index == 4'd0))
        else $error("empty dump not a single result at index 0");

    a_full_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> !o_no_entry)
        else $error("full status on an empty list");

    a_empty_del: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> o_no_entry)
        else $error("empty-delete status with entries present");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value_res) && $stable(o_index)
            && $stable(o_last) && $stable(o_status))
        else $error("stalled result changed");

endmodule

bind positional_insert_delete_array_core pida_checker u_pida_checker (.*);
